// File: rtl/sample_zone_matcher_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sample zone matcher
// Clocked property wrappers used by the checker.
// ----------------------------------------------------------------------------
`ifndef SAMPLE_ZONE_MATCHER_TOP_MACROS_SVH
`define SAMPLE_ZONE_MATCHER_TOP_MACROS_SVH

// Property checked outside reset only.
`define SZM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every edge, reset included.
`define SZM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/szm_pkg.sv
// ----------------------------------------------------------------------------
// szm_pkg
// Shared types and constants of the sample zone matcher.
// ----------------------------------------------------------------------------
package szm_pkg;

    localparam int NUM_CONTROLLERS = 128;
    localparam int CC_W            = 7;

    localparam logic [2:0] KIND_CONTROLLER = 3'd4;

    typedef enum logic [1:0] {
        FUNC_TRIGGER  = 2'd0,
        FUNC_SET_CC   = 2'd1,
        FUNC_CC_RANGE = 2'd2,
        FUNC_ON_RANGE = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        CFG_KEY_RANGE = 3'd0,
        CFG_VEL_RANGE = 3'd1,
        CFG_RND_RANGE = 3'd2,
        CFG_TRIG_KIND = 3'd3,
        CFG_USE_CC    = 3'd4,
        CFG_SEQ_LEN   = 3'd5,
        CFG_SEQ_POS   = 3'd6
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    // Scan token handed from cell to cell.
    typedef struct packed {
        logic            valid;
        logic            cc_ok;
        logic            on_ok;
        logic [CC_W-1:0] cc;
        logic [CC_W-1:0] ccv;
    } t_token;

    // Table write broadcast to every cell.
    typedef struct packed {
        logic            en;
        t_func           func;
        logic [CC_W-1:0] cc;
        logic [CC_W-1:0] value;
        logic [7:0]      low;
        logic [7:0]      high;
    } t_cell_wr;

endpackage

// File: rtl/szm_cell.sv
// ----------------------------------------------------------------------------
// szm_cell
// Holds one controller's value and ranges; checks the passing scan token.
// ----------------------------------------------------------------------------
module szm_cell
    import szm_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [CC_W-1:0] i_index,
    input  t_cell_wr        i_wr,
    input  t_token          i_tok,
    output t_token          o_tok
);

    logic [CC_W-1:0] r_value;
    logic [CC_W-1:0] r_low;
    logic [CC_W-1:0] r_high;
    logic [7:0]      r_on_low;
    logic [7:0]      r_on_high;
    t_token          r_tok;
    t_token          n_tok;
    logic            sel;
    logic            in_range;
    logic            on_hit;

    function automatic logic [CC_W-1:0] sat7(input logic [7:0] v);
        sat7 = v[7] ? '0 : v[CC_W-1:0];
    endfunction

    assign sel = (i_wr.cc == i_index);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value   <= '0;
            r_low     <= '0;
            r_high    <= '1;
            r_on_low  <= '1;
            r_on_high <= '1;
        end else if (i_wr.en && sel) begin
            unique case (i_wr.func)
                FUNC_SET_CC: begin
                    r_value <= i_wr.value;
                end
                FUNC_CC_RANGE: begin
                    r_low  <= sat7(i_wr.low);
                    r_high <= sat7(i_wr.high);
                end
                FUNC_ON_RANGE: begin
                    r_on_low  <= i_wr.low;
                    r_on_high <= i_wr.high;
                end
                FUNC_TRIGGER: begin
                end
            endcase
        end
    end

    always_comb begin
        // a full 0..127 range never blocks
        in_range = ((r_low == '0) && (r_high == '1)) ||
                   ((r_low <= r_value) && (r_high >= r_value));
        on_hit   = (i_tok.cc == i_index) &&
                   ($signed(r_on_low) <= $signed({1'b0, i_tok.ccv})) &&
                   ($signed(r_on_high) >= $signed({1'b0, i_tok.ccv}));
        n_tok       = i_tok;
        n_tok.cc_ok = i_tok.cc_ok & in_range;
        n_tok.on_ok = i_tok.on_ok | on_hit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

// File: rtl/sample_zone_matcher_top.sv
// ----------------------------------------------------------------------------
// sample_zone_matcher_top: one sampler zone checked against trigger events
// A table write's result passes through the ST_DONE state and the output register;
// a trigger event's scan token crosses all NUM_CONTROLLERS cells, one cell a cycle.
// One item in flight: no new input is taken until the last result is loaded,
// and a waiting result that holds the output also holds off the next input.
// Reset (synchronous, active low) restores tables, counter and all but the event registers.
// ----------------------------------------------------------------------------
module sample_zone_matcher_top
    import szm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // key[6:0] velocity[13:7] event_kind[16:14] random_value[32:17]
    // cc_number[39:33] cc_value[46:40] range_low[54:47] range_high[62:55]
    input  logic [63:0] s_axis_tdata,
    // func[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // fires[0]
    output logic [7:0]  m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [33:0] i_cfg_data
);

    t_state r_state, n_state;

    logic [13:0] r_key_range;
    logic [13:0] r_vel_range;
    logic [33:0] r_rnd_range;
    logic [2:0]  r_trig_kind;
    logic        r_use_cc;
    logic [7:0]  r_seq_len;
    logic [7:0]  r_seq_pos;
    logic [7:0]  r_rr;

    logic [6:0]  r_key;
    logic [6:0]  r_vel;
    logic [2:0]  r_kind;
    logic [15:0] r_rnd;
    logic        r_fires;
    logic        r_out_valid;
    logic        r_out_fires;

    logic        in_acc;
    logic        load_out;
    logic        scan_end;
    logic        base_ok;
    logic        pass;
    logic [8:0]  rr_inc;
    t_func       in_func;
    t_cell_wr    wr;
    t_token      tok [NUM_CONTROLLERS+1];

    assign in_func       = t_func'(s_axis_tuser);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'b0, r_out_fires};
    assign scan_end      = tok[NUM_CONTROLLERS].valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_range <= 14'd127;
            r_vel_range <= 14'd127;
            r_rnd_range <= 34'd65536;
            r_trig_kind <= '0;
            r_use_cc    <= 1'b0;
            r_seq_len   <= '0;
            r_seq_pos   <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_KEY_RANGE: r_key_range <= i_cfg_data[13:0];
                CFG_VEL_RANGE: r_vel_range <= i_cfg_data[13:0];
                CFG_RND_RANGE: r_rnd_range <= i_cfg_data;
                CFG_TRIG_KIND: r_trig_kind <= i_cfg_data[2:0];
                CFG_USE_CC:    r_use_cc    <= i_cfg_data[0];
                CFG_SEQ_LEN:   r_seq_len   <= i_cfg_data[7:0];
                CFG_SEQ_POS:   r_seq_pos   <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // Broadcast table writes and launch the scan token at the transfer.
    always_comb begin
        wr.en    = in_acc && (in_func != FUNC_TRIGGER);
        wr.func  = in_func;
        wr.cc    = s_axis_tdata[39:33];
        wr.value = s_axis_tdata[46:40];
        wr.low   = s_axis_tdata[54:47];
        wr.high  = s_axis_tdata[62:55];

        tok[0].valid = in_acc && (in_func == FUNC_TRIGGER);
        tok[0].cc_ok = 1'b1;
        tok[0].on_ok = 1'b0;
        tok[0].cc    = s_axis_tdata[39:33];
        tok[0].ccv   = s_axis_tdata[46:40];
    end

    for (genvar i = 0; i < NUM_CONTROLLERS; i++) begin : g_cell
        szm_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_index (CC_W'(i)),
            .i_wr    (wr),
            .i_tok   (tok[i]),
            .o_tok   (tok[i+1])
        );
    end

    always_comb begin
        base_ok = (r_kind == r_trig_kind) &&
                  ({1'b0, r_rnd} >= r_rnd_range[33:17]) &&
                  ({1'b0, r_rnd} <  r_rnd_range[16:0]);
        if (r_kind != KIND_CONTROLLER) begin
            base_ok = base_ok &&
                      (r_key >= r_key_range[13:7]) && (r_key <= r_key_range[6:0]) &&
                      (r_vel >= r_vel_range[13:7]) && (r_vel <= r_vel_range[6:0]);
        end
        pass = base_ok &&
               (!r_use_cc || tok[NUM_CONTROLLERS].cc_ok) &&
               ((r_trig_kind != KIND_CONTROLLER) || tok[NUM_CONTROLLERS].on_ok);
        rr_inc = {1'b0, r_rr} + 9'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        load_out      = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_state = (in_func == FUNC_TRIGGER) ? ST_SCAN : ST_DONE;
                end
            end
            ST_SCAN: begin
                if (scan_end) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_key  <= s_axis_tdata[6:0];
            r_vel  <= s_axis_tdata[13:7];
            r_kind <= s_axis_tdata[16:14];
            r_rnd  <= s_axis_tdata[32:17];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rr    <= '0;
            r_fires <= 1'b0;
        end else if (in_acc) begin
            r_fires <= 1'b0;
        end else if ((r_state == ST_SCAN) && scan_end) begin
            r_fires <= pass && (r_rr == r_seq_pos);
            if (pass) begin
                // wrap once the count passes the sequence length
                r_rr <= (rr_inc > {1'b0, r_seq_len}) ? '0 : rr_inc[7:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_out_fires <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
            r_out_fires <= r_fires;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

endmodule

// File: rtl/szm_checker.sv
// ----------------------------------------------------------------------------
// szm_checker
// Port-level checks of the sample zone matcher, bound to the top level.
// ----------------------------------------------------------------------------
`include "sample_zone_matcher_top_macros.svh"

module szm_checker
    import szm_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [1:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata
);

    // hold a stalled result
    `SZM_ASSERT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

    // reset empties the output register
    `SZM_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !m_axis_tvalid, "result valid after reset")

    // one item at a time
    `SZM_ASSERT(a_single_item, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "input taken while an item is in flight")

    // a table write taken while the output is empty gives a non-firing result
    `SZM_ASSERT(a_write_result, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready && (s_axis_tuser != FUNC_TRIGGER) && !m_axis_tvalid |=> ##1 (m_axis_tvalid && !m_axis_tdata[0]), "table write result missing or firing")

endmodule

bind sample_zone_matcher_top szm_checker u_szm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: sample zone matcher testbench
// Streams trigger events, controller updates and range table writes into the
// zone matcher, predicts the fires flag of every transfer in the bench, and
// compares it with each result. Zone registers change only between phases,
// while nothing is in flight. Both stream sides idle at random, and the
// result side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import szm_pkg::*;

    localparam int         CYCLE_LIMIT    = 1_000_000;
    localparam logic [2:0] CFG_UNUSED_IDX = 3'd7;

    typedef struct {
        t_func             func;
        logic [6:0]        key;
        logic [6:0]        vel;
        logic [2:0]        kind;
        logic [15:0]       rnd;
        logic [6:0]        cc;
        logic [6:0]        ccv;
        logic signed [7:0] rlo;
        logic signed [7:0] rhi;
    } t_zone_item;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [33:0] i_cfg_data;

    // Zone registers as the bench expects them
    logic [13:0] key_rng;
    logic [13:0] vel_rng;
    logic [33:0] rnd_rng;
    logic [2:0]  zone_kind;
    logic        cc_check;
    logic [7:0]  seq_len;
    logic [7:0]  seq_pos;

    // Controller tables and round-robin counter
    logic [6:0]        cc_val    [NUM_CONTROLLERS];
    logic [6:0]        cc_lo_tab [NUM_CONTROLLERS];
    logic [6:0]        cc_hi_tab [NUM_CONTROLLERS];
    logic signed [7:0] on_lo_tab [NUM_CONTROLLERS];
    logic signed [7:0] on_hi_tab [NUM_CONTROLLERS];
    logic [7:0]        rr_count;

    bit fires_expected[$];
    int error_count   = 0;
    int cycle_count   = 0;
    int hold_request  = 0;
    bit steady        = 1'b0;

    always #5 i_clk = ~i_clk;

    sample_zone_matcher_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // Update the tables for one accepted item and return whether the zone fires.
    function automatic bit apply_item(input t_zone_item it);
        logic [8:0] next_count;
        logic [7:0] prev_count;
        if (it.func == FUNC_SET_CC) begin
            cc_val[it.cc] = it.ccv;
            return 1'b0;
        end
        if (it.func == FUNC_CC_RANGE) begin
            cc_lo_tab[it.cc] = it.rlo[7] ? 7'd0 : it.rlo[6:0];
            cc_hi_tab[it.cc] = it.rhi[7] ? 7'd0 : it.rhi[6:0];
            return 1'b0;
        end
        if (it.func == FUNC_ON_RANGE) begin
            on_lo_tab[it.cc] = it.rlo;
            on_hi_tab[it.cc] = it.rhi;
            return 1'b0;
        end
        // Key and velocity do not matter for controller triggers
        if (it.kind != KIND_CONTROLLER &&
            (it.key < key_rng[13:7] || it.key > key_rng[6:0] ||
             it.vel < vel_rng[13:7] || it.vel > vel_rng[6:0]))
            return 1'b0;
        if (!({1'b0, it.rnd} >= rnd_rng[33:17] && {1'b0, it.rnd} < rnd_rng[16:0]))
            return 1'b0;
        if (it.kind != zone_kind)
            return 1'b0;
        if (cc_check) begin
            for (int i = 0; i < NUM_CONTROLLERS; i++) begin
                if (!(cc_lo_tab[i] == 7'd0 && cc_hi_tab[i] == 7'd127) &&
                    (cc_lo_tab[i] > cc_val[i] || cc_hi_tab[i] < cc_val[i]))
                    return 1'b0;
            end
        end
        if (zone_kind == KIND_CONTROLLER &&
            !(on_lo_tab[it.cc] <= $signed({1'b0, it.ccv}) &&
              on_hi_tab[it.cc] >= $signed({1'b0, it.ccv})))
            return 1'b0;
        prev_count = rr_count;
        next_count = {1'b0, rr_count} + 9'd1;
        if (next_count > {1'b0, seq_len})
            next_count = 9'd0;
        rr_count = next_count[7:0];
        return prev_count == seq_pos;
    endfunction

    function automatic t_zone_item item_of(input t_func f, input logic [6:0] key,
                                           input logic [6:0] vel, input logic [2:0] kind,
                                           input logic [15:0] rnd, input logic [6:0] cc,
                                           input logic [6:0] ccv,
                                           input logic signed [7:0] rlo,
                                           input logic signed [7:0] rhi);
        t_zone_item it;
        it.func = f;
        it.key  = key;
        it.vel  = vel;
        it.kind = kind;
        it.rnd  = rnd;
        it.cc   = cc;
        it.ccv  = ccv;
        it.rlo  = rlo;
        it.rhi  = rhi;
        return it;
    endfunction

    // Mostly events that get past the range checks, mixed with table traffic.
    function automatic t_zone_item next_random_item();
        t_zone_item it;
        int pick;
        int lo;
        int hi;
        pick    = int'($urandom_range(0, 99));
        it.key  = 7'($urandom);
        it.vel  = 7'($urandom);
        it.kind = 3'($urandom_range(0, 4));
        it.rnd  = 16'($urandom);
        it.cc   = ($urandom_range(0, 9) < 7) ? 7'($urandom_range(0, 7))
                                             : 7'($urandom_range(0, 127));
        it.ccv  = 7'($urandom);
        it.rlo  = 8'(int'($urandom_range(0, 128)) - 1);
        it.rhi  = 8'(int'($urandom_range(0, 128)) - 1);
        if (pick < 55) begin
            it.func = FUNC_TRIGGER;
            if ($urandom_range(0, 3) != 0)
                it.kind = zone_kind;
            if (key_rng[13:7] <= key_rng[6:0] && $urandom_range(0, 3) != 0)
                it.key = 7'($urandom_range(key_rng[13:7], key_rng[6:0]));
            if (vel_rng[13:7] <= vel_rng[6:0] && $urandom_range(0, 3) != 0)
                it.vel = 7'($urandom_range(vel_rng[13:7], vel_rng[6:0]));
            lo = int'(rnd_rng[33:17]);
            hi = int'(rnd_rng[16:0]);
            if (hi > 65536)
                hi = 65536;
            if (lo < hi && $urandom_range(0, 4) != 0)
                it.rnd = 16'($urandom_range(lo, hi - 1));
            lo = int'(on_lo_tab[it.cc]);
            hi = int'(on_hi_tab[it.cc]);
            if (lo < 0)
                lo = 0;
            if (zone_kind == KIND_CONTROLLER && lo <= hi && $urandom_range(0, 2) != 0)
                it.ccv = 7'($urandom_range(lo, hi));
        end else if (pick < 72) begin
            it.func = FUNC_SET_CC;
            if (cc_lo_tab[it.cc] <= cc_hi_tab[it.cc] && $urandom_range(0, 3) != 0)
                it.ccv = 7'($urandom_range(cc_lo_tab[it.cc], cc_hi_tab[it.cc]));
        end else if (pick < 86) begin
            it.func = FUNC_CC_RANGE;
            lo = int'(cc_val[it.cc]);
            case ($urandom_range(0, 4))
                0, 1: begin
                    it.rlo = $urandom_range(0, 1) ? 8'sd0 : -8'sd1;
                    it.rhi = 8'sd127;
                end
                2, 3: begin
                    it.rlo = 8'(int'($urandom_range(0, lo + 1)) - 1);
                    it.rhi = 8'($urandom_range(lo, 127));
                end
                default: ;
            endcase
        end else begin
            it.func = FUNC_ON_RANGE;
            if ($urandom_range(0, 5) != 0) begin
                lo = int'($urandom_range(0, 128)) - 1;
                hi = lo + int'($urandom_range(0, 60));
                if (hi > 127)
                    hi = 127;
                it.rlo = 8'(lo);
                it.rhi = 8'(hi);
            end
        end
        return it;
    endfunction

    task automatic flag_error(input string what);
        error_count++;
        if (error_count <= 10)
            $display("%0t: %s", $time, what);
    endtask

    task automatic send_item(input t_zone_item it);
        int gap;
        gap = steady ? 0 : int'($urandom_range(0, 3));
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, it.rhi, it.rlo, it.ccv, it.cc, it.rnd, it.kind, it.vel, it.key};
        s_axis_tuser  <= it.func;
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        fires_expected.push_back(apply_item(it));
    endtask

    // Drop valid and let every outstanding result come back.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (fires_expected.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [33:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        case (idx)
            CFG_KEY_RANGE: key_rng   = value[13:0];
            CFG_VEL_RANGE: vel_rng   = value[13:0];
            CFG_RND_RANGE: rnd_rng   = value;
            CFG_TRIG_KIND: zone_kind = value[2:0];
            CFG_USE_CC:    cc_check  = value[0];
            CFG_SEQ_LEN:   seq_len   = value[7:0];
            CFG_SEQ_POS:   seq_pos   = value[7:0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_zone_config(input logic [13:0] key, input logic [13:0] vel,
                                     input logic [33:0] rnd, input logic [2:0] kind,
                                     input logic use_cc, input logic [7:0] len,
                                     input logic [7:0] pos);
        cfg_write(CFG_KEY_RANGE, {20'd0, key});
        cfg_write(CFG_VEL_RANGE, {20'd0, vel});
        cfg_write(CFG_RND_RANGE, rnd);
        cfg_write(CFG_TRIG_KIND, {31'd0, kind});
        cfg_write(CFG_USE_CC, {33'd0, use_cc});
        cfg_write(CFG_SEQ_LEN, {26'd0, len});
        cfg_write(CFG_SEQ_POS, {26'd0, pos});
    endtask

    task automatic load_random_zone(input int phase);
        logic [6:0]  klo, khi, vlo, vhi;
        logic [16:0] rlo, rhi;
        logic [13:0] key, vel;
        logic [33:0] rnd;
        logic [2:0]  kind;
        logic [7:0]  len, pos;
        klo  = 7'($urandom_range(0, 60));
        khi  = 7'($urandom_range(klo, 127));
        vlo  = 7'($urandom_range(0, 60));
        vhi  = 7'($urandom_range(vlo, 127));
        key  = ($urandom_range(0, 5) == 0) ? 14'($urandom) : {klo, khi};
        vel  = ($urandom_range(0, 5) == 0) ? 14'($urandom) : {vlo, vhi};
        rlo  = 17'($urandom_range(0, 20000));
        rhi  = 17'($urandom_range(rlo + 1, 70000));
        rnd  = (phase == 9) ? {2'($urandom), 32'($urandom)} : {rlo, rhi};
        kind = (phase == 2 || phase == 7) ? KIND_CONTROLLER : 3'($urandom_range(0, 4));
        len  = (phase == 4) ? 8'd255 : 8'($urandom_range(0, 4));
        pos  = 8'($urandom_range(0, len + 1));
        if (phase == 0)
            write_zone_config(14'd127, 14'd127, 34'd65536, 3'd0, 1'b0, 8'd0, 8'd0);
        else
            write_zone_config(key, vel, rnd, kind, 1'($urandom_range(0, 1)), len, pos);
    endtask

    task automatic test_directed_items();
        // Default zone: full ranges, attack trigger, every passing event fires
        send_item(item_of(FUNC_TRIGGER, 7'd0, 7'd0, 3'd0, 16'h0000, 7'd0, 7'd0,
                          8'sd0, 8'sd0));
        send_item(item_of(FUNC_TRIGGER, 7'd127, 7'd127, 3'd0, 16'hFFFF, 7'd127, 7'd127,
                          -8'sd1, -8'sd1));
        for (int k = 1; k < 8; k++)
            send_item(item_of(FUNC_TRIGGER, 7'd64, 7'd64, 3'(k), 16'h1234, 7'd0, 7'd0,
                              8'sd0, 8'sd0));
        send_item(item_of(FUNC_SET_CC, 7'd0, 7'd0, 3'd0, 16'h0, 7'd127, 7'd127,
                          8'sd0, 8'sd0));
        // Negative low bound saturates to zero: full range again
        send_item(item_of(FUNC_CC_RANGE, 7'd0, 7'd0, 3'd0, 16'h0, 7'd127, 7'd0,
                          -8'sd1, 8'sd127));
        send_item(item_of(FUNC_ON_RANGE, 7'd0, 7'd0, 3'd0, 16'h0, 7'd0, 7'd0,
                          -8'sd1, 8'sd127));
        // Inverted on-range: no controller value can pass
        send_item(item_of(FUNC_ON_RANGE, 7'd0, 7'd0, 3'd0, 16'h0, 7'd127, 7'd0,
                          8'sd127, -8'sd1));
        wait_idle();
    endtask

    task automatic test_controller_checks();
        write_zone_config(14'd127, 14'd127, 34'd65536, 3'd0, 1'b1, 8'd0, 8'd0);
        send_item(item_of(FUNC_CC_RANGE, 7'd0, 7'd0, 3'd0, 16'h0, 7'd5, 7'd0,
                          8'sd10, 8'sd20));
        send_item(item_of(FUNC_TRIGGER, 7'd60, 7'd60, 3'd0, 16'h100, 7'd0, 7'd0,
                          8'sd0, 8'sd0));
        send_item(item_of(FUNC_SET_CC, 7'd0, 7'd0, 3'd0, 16'h0, 7'd5, 7'd15,
                          8'sd0, 8'sd0));
        send_item(item_of(FUNC_TRIGGER, 7'd60, 7'd60, 3'd0, 16'h100, 7'd0, 7'd0,
                          8'sd0, 8'sd0));
        wait_idle();
        // Narrow key and velocity ranges must not block controller triggers
        write_zone_config({7'd60, 7'd61}, {7'd60, 7'd61}, 34'd65536, KIND_CONTROLLER,
                          1'b1, 8'd0, 8'd0);
        send_item(item_of(FUNC_TRIGGER, 7'd0, 7'd127, KIND_CONTROLLER, 16'h0, 7'd0,
                          7'd127, 8'sd0, 8'sd0));
        send_item(item_of(FUNC_TRIGGER, 7'd0, 7'd0, KIND_CONTROLLER, 16'h0, 7'd127,
                          7'd0, 8'sd0, 8'sd0));
        wait_idle();
    endtask

    task automatic test_config_extremes();
        write_zone_config(14'h3FFF, 14'h3FFF, 34'h3_FFFF_FFFF, 3'd7, 1'b1, 8'd255, 8'd255);
        cfg_write(CFG_UNUSED_IDX, 34'h3_FFFF_FFFF);
        send_item(item_of(FUNC_TRIGGER, 7'd127, 7'd127, 3'd7, 16'hFFFF, 7'd3, 7'd3,
                          8'sd0, 8'sd0));
        wait_idle();
        cfg_write(CFG_RND_RANGE, {17'd0, 17'h1_FFFF});
        send_item(item_of(FUNC_TRIGGER, 7'd127, 7'd127, 3'd7, 16'hFFFF, 7'd3, 7'd3,
                          8'sd0, 8'sd0));
        wait_idle();
        write_zone_config(14'd0, 14'd0, 34'd0, 3'd0, 1'b0, 8'd0, 8'd0);
        send_item(item_of(FUNC_TRIGGER, 7'd0, 7'd0, 3'd0, 16'h0, 7'd0, 7'd0,
                          8'sd0, 8'sd0));
        wait_idle();
    endtask

    task automatic test_backpressure();
        write_zone_config(14'd127, 14'd127, 34'd65536, 3'd0, 1'b0, 8'd2, 8'd1);
        steady       = 1'b1;
        hold_request = 400;
        repeat (8)
            send_item(item_of(FUNC_TRIGGER, 7'($urandom), 7'($urandom), 3'd0,
                              16'($urandom), 7'($urandom), 7'($urandom),
                              8'sd0, 8'sd0));
        steady = 1'b0;
        wait_idle();
    endtask

    task automatic test_random_phases();
        for (int phase = 0; phase < 10; phase++) begin
            load_random_zone(phase);
            steady = (phase == 5);
            repeat (150)
                send_item(next_random_item());
            steady = 1'b0;
            wait_idle();
        end
    endtask

    // Result side: random stall after each transfer, long hold when requested
    initial begin : result_sink
        int wait_left;
        wait_left = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request > 0) begin
                wait_left    = hold_request;
                hold_request = 0;
            end else if (m_axis_tvalid && m_axis_tready) begin
                wait_left = steady ? 0 : int'($urandom_range(0, 3));
            end else if (wait_left > 0) begin
                wait_left--;
            end
            m_axis_tready <= (wait_left == 0);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (fires_expected.size() == 0)
                flag_error($sformatf("result with nothing expected, fires %0b",
                                     m_axis_tdata[0]));
            else if (m_axis_tdata[0] !== fires_expected[0])
                flag_error($sformatf("fires mismatch: expected %0b, got %0b",
                                     fires_expected.pop_front(), m_axis_tdata[0]));
            else
                void'(fires_expected.pop_front());
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** sample_zone_matcher_top: FAILED **");
            $finish;
        end
    end

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= FUNC_TRIGGER;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= CFG_KEY_RANGE;
        i_cfg_data    <= '0;
        key_rng   = 14'd127;
        vel_rng   = 14'd127;
        rnd_rng   = 34'd65536;
        zone_kind = 3'd0;
        cc_check  = 1'b0;
        seq_len   = 8'd0;
        seq_pos   = 8'd0;
        rr_count  = 8'd0;
        for (int i = 0; i < NUM_CONTROLLERS; i++) begin
            cc_val[i]    = 7'd0;
            cc_lo_tab[i] = 7'd0;
            cc_hi_tab[i] = 7'd127;
            on_lo_tab[i] = -8'sd1;
            on_hi_tab[i] = -8'sd1;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_items();
        test_controller_checks();
        test_config_extremes();
        test_backpressure();
        test_random_phases();

        wait_idle();
        repeat (NUM_CONTROLLERS + 8) @(posedge i_clk);
        if (error_count == 0 && fires_expected.size() == 0) begin
            $display("** sample_zone_matcher_top: PASSED **");
        end else begin
            $display("** sample_zone_matcher_top: FAILED **");
        end
        $finish;
    end

endmodule
